// ===== rtl/core/sem_pkg.sv =====
// Shared types and constants for the RGB Sobel edge magnitude block.
// No dependencies.
package sem_pkg;

  localparam int CFG_W   = 11;
  localparam int ROW_W   = 11;
  localparam int SZ_W    = 13;
  localparam int PIX_W   = 24;
  localparam int SUM_W   = 21;
  localparam int GRAD_W  = 12;
  localparam int ROOT_W  = 9;
  localparam logic [ROW_W-1:0] ROW_MAX = 11'd2047;
  localparam logic [7:0] MAG_CAP = 8'd255;
  // above 256*256+254 the nearest root is capped
  localparam logic [SUM_W-1:0] ROOT_LIM = 21'd65790;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  typedef enum logic {F_IDLE, F_WRITE} f_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_GRAD, B_SQX, B_SQY, B_ROOT, B_RND, B_OUT
  } b_state_t;

  // one result's window, pixels outside the frame already zeroed
  typedef struct packed {
    logic [8:0][PIX_W-1:0] px;
    logic                  last;
  } sem_job_t;

endpackage

// ===== rtl/core/sem_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/sem_front.sv =====
// Front end: accepts pixels, keeps the line stores and the 3x3 window,
// classifies each position and queues windows that produce a result. Uses sem_pkg, sem_ram.
module sem_front import sem_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_red_in,
  input  logic [7:0]       in_green_in,
  input  logic [7:0]       in_blue_in,
  input  logic             in_drain,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             q_full,
  output logic             q_push,
  output sem_job_t         q_data
);

  localparam int AW = $clog2(MAX_WIDTH);

  f_state_t state_r, state_nxt;
  logic [CFG_W-1:0] width_r, height_r;
  logic [AW-1:0]    col_r, addr_r;
  logic [ROW_W-1:0] row_r;
  logic [PIX_W-1:0] pix_r;
  logic [8:0]       keep_r;
  logic             emit_r, last_r;
  logic [8:0][PIX_W-1:0] win_r, win_nxt;
  logic [PIX_W-1:0] up_q, mid_q;

  logic [SZ_W-1:0] w_eff, h_eff, col_x, row_x, cr, cc;
  logic            accept, wrap, emit, last;
  logic [8:0]      keep;

  always_comb begin
    if (width_r == '0) begin
      w_eff = SZ_W'(1);
    end else if (SZ_W'(width_r) > SZ_W'(MAX_WIDTH)) begin
      w_eff = SZ_W'(MAX_WIDTH);
    end else begin
      w_eff = SZ_W'(width_r);
    end
    if (height_r == '0) begin
      h_eff = SZ_W'(1);
    end else if (SZ_W'(height_r) > SZ_W'(MAX_HEIGHT)) begin
      h_eff = SZ_W'(MAX_HEIGHT);
    end else begin
      h_eff = SZ_W'(height_r);
    end
  end

  // position classification for the item being accepted
  always_comb begin
    col_x = SZ_W'(col_r);
    row_x = SZ_W'(row_r);
    wrap  = (col_x + SZ_W'(1)) >= w_eff;
    if (col_r != '0) begin
      emit = row_r >= ROW_W'(1);
      cr   = row_x - SZ_W'(1);
      cc   = col_x - SZ_W'(1);
    end else begin
      emit = row_r >= ROW_W'(2);
      cr   = row_x - SZ_W'(2);
      cc   = w_eff - SZ_W'(1);
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        keep[r*3+c] = !((r == 0 && cr == '0) ||
                        (r == 2 && (cr + SZ_W'(1)) >= h_eff) ||
                        (c == 0 && cc == '0) ||
                        (c == 2 && (cc + SZ_W'(1)) >= w_eff) ||
                        (cr >= h_eff));
      end
    end
    last = emit && (cr + SZ_W'(1) == h_eff) && (cc + SZ_W'(1) == w_eff);
  end

  always_comb begin
    unique case (state_r)
      F_IDLE:  state_nxt = accept ? F_WRITE : F_IDLE;
      F_WRITE: state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != F_IDLE) || q_full;
    accept   = in_valid && !in_stall;
    q_push   = (state_r == F_WRITE) && emit_r;
  end

  always_comb begin
    win_nxt = win_r;
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]   = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = up_q;
    win_nxt[5] = mid_q;
    win_nxt[8] = pix_r;
    for (int k = 0; k < 9; k++) begin
      q_data.px[k] = win_nxt[k] & {PIX_W{keep_r[k]}};
    end
    q_data.last = last_r;
  end

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .wr_en(state_r == F_WRITE), .wr_addr(addr_r), .wr_data(mid_q),
    .rd_en(accept), .rd_addr(col_r), .rd_data(up_q)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk(clk), .wr_en(state_r == F_WRITE), .wr_addr(addr_r), .wr_data(pix_r),
    .rd_en(accept), .rd_addr(col_r), .rd_data(mid_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      width_r  <= CFG_W'(1024);
      height_r <= CFG_W'(1024);
      col_r    <= '0;
      row_r    <= '0;
      emit_r   <= 1'b0;
      win_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_WRITE) begin
        win_r <= win_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IDX_WIDTH:  width_r  <= cfg_data;
          CFG_IDX_HEIGHT: height_r <= cfg_data;
          default:        width_r  <= cfg_data;
        endcase
        col_r <= '0;
        row_r <= '0;
      end else if (accept) begin
        emit_r <= emit;
        if (last) begin
          col_r <= '0;
          row_r <= '0;
        end else if (wrap) begin
          col_r <= '0;
          if (row_r != ROW_MAX) begin
            row_r <= row_r + ROW_W'(1);
          end
        end else begin
          col_r <= col_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r  <= in_drain ? '0 : {in_blue_in, in_green_in, in_red_in};
      addr_r <= col_r;
      keep_r <= keep;
      last_r <= last;
    end
  end

  a_accept_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == F_WRITE))
    else $error("front did not move to line store update after transfer");

endmodule

// ===== rtl/core/sem_queue.sv =====
// Two-entry queue of windows between front end and magnitude unit.
// Uses sem_pkg.
module sem_queue import sem_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  sem_job_t push_data,
  input  logic     pop,
  output sem_job_t head,
  output logic     full,
  output logic     empty
);

  sem_job_t  ent_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;

  assign head  = ent_r[rp_r];
  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue pop while empty");

endmodule

// ===== rtl/core/sem_back.sv =====
// Magnitude unit: per channel Sobel gradients, squares and nearest integer
// root on one shared multiplier, then the output register. Uses sem_pkg.
module sem_back import sem_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  sem_job_t q_head,
  input  logic     q_empty,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_stall,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  output logic     out_last_of_frame
);

  b_state_t state_r, state_nxt;
  sem_job_t job_r;
  logic [1:0] chan_r;
  logic [2:0] bit_r;
  logic signed [GRAD_W-1:0] gx_r, gy_r, gx, gy;
  logic [SUM_W-1:0]  s_r;
  logic [ROOT_W-1:0] r_r, t;
  logic [2:0][7:0]   res_r;
  logic              out_valid_r;
  logic signed [GRAD_W-1:0] mul_a, mul_b;
  logic signed [2*GRAD_W-1:0] prod;
  logic [2*GRAD_W-1:0] prod_u;
  logic [GRAD_W-1:0] p [9];
  logic [ROOT_W-1:0] r_fin;
  logic [7:0]        mag;
  logic              load_out;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      unique case (chan_r)
        2'd0:    p[k] = GRAD_W'(job_r.px[k][7:0]);
        2'd1:    p[k] = GRAD_W'(job_r.px[k][15:8]);
        default: p[k] = GRAD_W'(job_r.px[k][23:16]);
      endcase
    end
    gx = signed'((p[2] + (p[5] << 1) + p[8]) - (p[0] + (p[3] << 1) + p[6]));
    gy = signed'((p[6] + (p[7] << 1) + p[8]) - (p[0] + (p[1] << 1) + p[2]));
  end

  assign t = r_r | (ROOT_W'(1) << bit_r);

  always_comb begin
    unique case (state_r)
      B_SQX:   begin mul_a = gx_r; mul_b = gx_r; end
      B_SQY:   begin mul_a = gy_r; mul_b = gy_r; end
      B_ROOT:  begin mul_a = signed'(GRAD_W'(t)); mul_b = signed'(GRAD_W'(t)); end
      default: begin mul_a = signed'(GRAD_W'(r_r)); mul_b = signed'(GRAD_W'(r_r)); end
    endcase
    prod   = mul_a * mul_b;
    prod_u = unsigned'(prod);
  end

  always_comb begin
    r_fin = (2*GRAD_W)'(s_r) > prod_u + (2*GRAD_W)'(r_r) ? r_r + ROOT_W'(1) : r_r;
    if (s_r > ROOT_LIM || r_fin > ROOT_W'(MAG_CAP)) begin
      mag = MAG_CAP;
    end else begin
      mag = r_fin[7:0];
    end
  end

  always_comb begin
    unique case (state_r)
      B_IDLE:  state_nxt = q_empty ? B_IDLE : B_GRAD;
      B_GRAD:  state_nxt = B_SQX;
      B_SQX:   state_nxt = B_SQY;
      B_SQY:   state_nxt = B_ROOT;
      B_ROOT:  state_nxt = (bit_r == '0) ? B_RND : B_ROOT;
      B_RND:   state_nxt = (chan_r == 2'd2) ? B_OUT : B_GRAD;
      B_OUT:   state_nxt = (!out_valid_r || !out_stall) ? B_IDLE : B_OUT;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state_r == B_IDLE) && !q_empty;
    load_out = (state_r == B_OUT) && (!out_valid_r || !out_stall);
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        job_r  <= q_head;
        chan_r <= '0;
      end
      B_GRAD: begin
        gx_r <= gx;
        gy_r <= gy;
      end
      B_SQX: s_r <= prod_u[SUM_W-1:0];
      B_SQY: begin
        s_r   <= s_r + prod_u[SUM_W-1:0];
        r_r   <= '0;
        bit_r <= 3'd7;
      end
      B_ROOT: begin
        if (prod_u <= (2*GRAD_W)'(s_r)) begin
          r_r <= t;
        end
        bit_r <= bit_r - 3'd1;
      end
      B_RND: begin
        res_r[chan_r] <= mag;
        chan_r <= chan_r + 2'd1;
      end
      B_OUT: begin
        if (load_out) begin
          out_red_out       <= res_r[0];
          out_green_out     <= res_r[1];
          out_blue_out      <= res_r[2];
          out_last_of_frame <= job_r.last;
        end
      end
      default: ;
    endcase
  end

  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RND) |-> (r_r <= ROOT_W'(MAG_CAP)))
    else $error("root search went past the cap");

endmodule

// ===== rtl/core/sobel_edge_magnitude_rgb.sv =====
// RGB Sobel edge magnitude, zero padded 3x3 window, result lags input by width+1 items.
// In the front end each pixel transfer is a line store read, then a write and window shift.
// In the magnitude unit each result is a queue pop, 12 steps per channel on one
// shared multiplier (gradient, two squares, eight root bits, rounding), then the output register.
// A two-entry window queue lets the front run ahead; the back pops a window only when idle.
// Synchronous active-low reset: size registers 1024, position zero, line stores not cleared.
module sobel_edge_magnitude_rgb import sem_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_red_in,
  input  logic [7:0]       in_green_in,
  input  logic [7:0]       in_blue_in,
  input  logic             in_drain,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic             out_last_of_frame,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  sem_job_t push_data, head;
  logic     push, pop, full, empty;

  sem_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red_in(in_red_in), .in_green_in(in_green_in), .in_blue_in(in_blue_in),
    .in_drain(in_drain),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_full(full), .q_push(push), .q_data(push_data)
  );

  sem_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
    .pop(pop), .head(head), .full(full), .empty(empty)
  );

  sem_back u_back (
    .clk(clk), .rst_n(rst_n), .q_head(head), .q_empty(empty), .q_pop(pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red_out(out_red_out), .out_green_out(out_green_out),
    .out_blue_out(out_blue_out), .out_last_of_frame(out_last_of_frame)
  );

endmodule

// ===== tb/tb_sobel_edge_magnitude_rgb.sv =====
// Testbench for sobel_edge_magnitude_rgb: directed table, then random frames of random sizes.
// Results are checked against a behavioral Sobel magnitude predictor kept in this file.
// Depends on rtl/core/sem_pkg.sv and rtl/core/sobel_edge_magnitude_rgb.sv.
`timescale 1ns / 1ps

module tb_sobel_edge_magnitude_rgb;
  import sem_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } mag_t;

  typedef enum logic [1:0] {OP_PIX, OP_SET_W, OP_SET_H} op_t;

  typedef struct packed {
    op_t         op;
    logic [10:0] val;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        drain;
    logic        typed;
    mag_t        want;
  } row_t;

  localparam int NROWS = 24;
  localparam int SETTLE = 120;
  localparam mag_t MAG_LAST0 = '{8'd0, 8'd0, 8'd0, 1'b1};
  localparam mag_t MAG_NONE = '0;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_red_in = '0;
  logic [7:0]       in_green_in = '0;
  logic [7:0]       in_blue_in = '0;
  logic             in_drain = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_red_out;
  logic [7:0]       out_green_out;
  logic [7:0]       out_blue_out;
  logic             out_last_of_frame;
  logic             cfg_we = 1'b0;
  logic             cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  sobel_edge_magnitude_rgb i_dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [23:0] upper_line [1024];
  logic [23:0] middle_line [1024];
  logic [23:0] win [9];
  int          col_pos;
  int          row_pos;
  logic [10:0] width_reg;
  logic [10:0] height_reg;

  mag_t mag_q[$];
  int   err_cnt = 0;
  int   snd_idle = 0;
  int   rcv_idle = 0;
  row_t dir_rows [NROWS];

  function automatic int eff_size(logic [10:0] v);
    if (v == 0) return 1;
    if (v > 1024) return 1024;
    return v;
  endfunction

  function automatic logic [7:0] round_root(int s);
    int r;
    r = 0;
    if (s > 255 * 255 + 255) return 8'd255;
    while ((r + 1) * (r + 1) <= s) r++;
    if (s > r * r + r) r++;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic logic [7:0] chan_mag(bit keep [9], int sh);
    int gx, gy, v;
    gx = 0;
    gy = 0;
    for (int k = 0; k < 9; k++) begin
      if (keep[k]) begin
        v = (win[k] >> sh) & 8'hFF;
        gx += ((k % 3) - 1) * ((k % 3 == 1) ? 0 : ((k / 3 == 1) ? 2 : 1)) * v;
        gy += ((k / 3) - 1) * ((k / 3 == 1) ? 0 : ((k % 3 == 1) ? 2 : 1)) * v;
      end
    end
    return round_root(gx * gx + gy * gy);
  endfunction

  task automatic predict_pixel(input logic [7:0] r, g, b, input logic d,
                               output bit has, output mag_t m);
    int w, h, col, row, cr, cc;
    logic [23:0] pix, up, mid;
    bit keep [9];
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    col = (col_pos < w) ? col_pos : 0;
    row = row_pos;
    pix = d ? 24'd0 : {b, g, r};
    up = upper_line[col];
    mid = middle_line[col];
    upper_line[col] = mid;
    middle_line[col] = pix;
    for (int i = 0; i < 3; i++) begin
      win[i * 3] = win[i * 3 + 1];
      win[i * 3 + 1] = win[i * 3 + 2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = pix;
    if (col + 1 >= w) begin
      col_pos = 0;
      if (row < 2047) row_pos = row + 1;
    end else begin
      col_pos = col + 1;
    end
    has = 1'b0;
    m = MAG_NONE;
    if (col >= 1) begin
      if (row < 1) return;
      cr = row - 1;
      cc = col - 1;
    end else begin
      if (row < 2) return;
      cr = row - 2;
      cc = w - 1;
    end
    for (int k = 0; k < 9; k++) begin
      keep[k] = !((k / 3 == 0 && cr == 0) || (k / 3 == 2 && cr + 1 >= h) ||
                  (k % 3 == 0 && cc == 0) || (k % 3 == 2 && cc + 1 >= w) || cr >= h);
    end
    has = 1'b1;
    m.red = chan_mag(keep, 0);
    m.green = chan_mag(keep, 8);
    m.blue = chan_mag(keep, 16);
    if (cr + 1 == h && cc + 1 == w) begin
      m.last = 1'b1;
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  task automatic wait_empty();
    while (mag_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [10:0] val);
    in_valid <= 1'b0;
    wait_empty();
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_WIDTH) width_reg = val;
    else height_reg = val;
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic send_pixel(input logic [7:0] r, g, b, input logic d,
                            input bit typed, input mag_t want);
    bit has;
    mag_t m;
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    in_drain <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pixel(r, g, b, d, has, m);
    if (typed) mag_q.push_back(want);
    else if (has) mag_q.push_back(m);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  always @(posedge clk) begin
    mag_t e;
    out_stall <= ($urandom_range(99) < rcv_idle);
    if (rst_n && out_valid && !out_stall) begin
      if (mag_q.size() == 0) begin
        $error("unexpected result transfer");
        err_cnt++;
      end else begin
        e = mag_q.pop_front();
        if (out_red_out !== e.red) begin
          $error("red_out: expected %0d, got %0d", e.red, out_red_out);
          err_cnt++;
        end
        if (out_green_out !== e.green) begin
          $error("green_out: expected %0d, got %0d", e.green, out_green_out);
          err_cnt++;
        end
        if (out_blue_out !== e.blue) begin
          $error("blue_out: expected %0d, got %0d", e.blue, out_blue_out);
          err_cnt++;
        end
        if (out_last_of_frame !== e.last) begin
          $error("last_of_frame: expected %0d, got %0d", e.last, out_last_of_frame);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int w, h, npix, cut, done_items, frame;
    dir_rows = '{
      '{OP_SET_W, 11'd1, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, MAG_NONE},
      '{OP_SET_H, 11'd1, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, MAG_NONE},
      '{OP_PIX, 11'd0, 8'd255, 8'd0, 8'd128, 1'b0, 1'b0, MAG_NONE},
      '{OP_PIX, 11'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, MAG_NONE},
      '{OP_PIX, 11'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, MAG_LAST0},
      '{OP_SET_W, 11'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, MAG_NONE},
      '{OP_SET_H, 11'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, MAG_NONE},
      '{OP_PIX, 11'd0, 8'd0, 8'd255, 8'd255, 1'b0, 1'b0, MAG_NONE},
      '{OP_PIX, 11'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, MAG_NONE},
      '{OP_PIX, 11'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1, MAG_LAST0},
      '{OP_SET_W, 11'd3, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, MAG_NONE},
      '{OP_SET_H, 11'd2, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, MAG_NONE},
      '{OP_PIX, 11'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, MAG_NONE},
      '{OP_PIX, 11'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, MAG_NONE},
      '{OP_PIX, 11'd0, 8'd255, 8'd0, 8'd255, 1'b0, 1'b0, MAG_NONE},
      '{OP_PIX, 11'd0, 8'd77, 8'd77, 8'd77, 1'b1, 1'b0, MAG_NONE},
      '{OP_PIX, 11'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, MAG_NONE},
      '{OP_PIX, 11'd0, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0, MAG_NONE},
      '{OP_PIX, 11'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, MAG_NONE},
      '{OP_PIX, 11'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, MAG_NONE},
      '{OP_PIX, 11'd0, 8'd200, 8'd1, 8'd99, 1'b0, 1'b0, MAG_NONE},
      '{OP_PIX, 11'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, MAG_NONE},
      '{OP_SET_W, 11'd2047, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, MAG_NONE},
      '{OP_SET_H, 11'd2047, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, MAG_NONE}
    };
    for (int i = 0; i < 1024; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    for (int k = 0; k < 9; k++) win[k] = '0;
    col_pos = 0;
    row_pos = 0;
    width_reg = 11'd1024;
    height_reg = 11'd1024;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].op)
        OP_SET_W: write_reg(CFG_IDX_WIDTH, dir_rows[i].val);
        OP_SET_H: write_reg(CFG_IDX_HEIGHT, dir_rows[i].val);
        default: send_pixel(dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue,
                            dir_rows[i].drain, dir_rows[i].typed, dir_rows[i].want);
      endcase
    end
    in_valid <= 1'b0;

    done_items = 0;
    frame = 0;
    while (done_items < 650 || frame < 10) begin
      if (frame == 3) begin
        w = 0;
        h = $urandom_range(1, 4);
      end else if (frame == 6) begin
        w = $urandom_range(1, 4);
        h = 0;
      end else if (frame == 8) begin
        w = 2047;
        h = 1;
      end else begin
        w = $urandom_range(1, 7);
        h = $urandom_range(1, 6);
      end
      write_reg(CFG_IDX_WIDTH, 11'(w));
      write_reg(CFG_IDX_HEIGHT, 11'(h));
      npix = eff_size(11'(w)) * eff_size(11'(h));
      cut = ($urandom_range(7) == 0) ? $urandom_range(npix) : -1;
      if (frame == 8) cut = 150;
      for (int p = 0; p < npix + eff_size(11'(w)) + 1; p++) begin
        if (p == cut) break;
        if (done_items < 217) begin
          snd_idle = 32;
          rcv_idle = 49;
        end else if (done_items < 434) begin
          snd_idle = 49;
          rcv_idle = 32;
        end else begin
          snd_idle = 0;
          rcv_idle = 0;
        end
        if (p < npix)
          send_pixel(rand_chan(), rand_chan(), rand_chan(), $urandom_range(9) == 0,
                     1'b0, MAG_NONE);
        else
          send_pixel(rand_chan(), rand_chan(), rand_chan(), $urandom_range(4) != 0,
                     1'b0, MAG_NONE);
        done_items++;
      end
      in_valid <= 1'b0;
      @(posedge clk);
      frame++;
    end

    wait_empty();
    repeat (200) @(posedge clk);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sobel_edge_magnitude_rgb.f =====
rtl/core/sem_pkg.sv
rtl/core/sem_ram.sv
rtl/core/sem_front.sv
rtl/core/sem_queue.sv
rtl/core/sem_back.sv
rtl/core/sobel_edge_magnitude_rgb.sv
tb/tb_sobel_edge_magnitude_rgb.sv
